// File: sv/evs_pkg.sv
package evs_pkg;

    localparam int DW          = 32;
    localparam int NUM_GRAD    = 9;
    localparam int NUM_IN      = 11;
    localparam int NCOMP       = 6;
    localparam int OW          = 48;
    localparam int IN_TDATA_W  = NUM_IN * DW;
    localparam int OUT_TDATA_W = NCOMP * OW;
    localparam int CFG_IDX_W   = 1;

    localparam int MW    = 34;
    localparam int DY2W  = DW + 1;
    localparam int SW    = 67;
    localparam int SQW   = 68;
    localparam int RTW   = SQW / 2;
    localparam int LW    = 67;
    localparam int RLW   = DW + LW;
    localparam int SCW   = RLW + RTW;
    localparam int PW    = SCW + MW;
    localparam int Q_SHIFT = 64;
    localparam int QW    = PW - Q_SHIFT;
    localparam int XW    = 49;
    localparam int QDW   = 48;

    localparam int SQ_SPS  = 2;
    localparam int MUL_LAT = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 1'b1;
    localparam logic [DW-1:0]        SPACING_RESET = 32'd65536;

    localparam logic [OW-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [OW-1:0] NEG_LIMIT = 48'h8000_0000_0000;

    localparam logic [QW-1:0] THR3_POS = QW'(52'h1_8000_0000_0000);
    localparam logic [QW-1:0] THR3_NEG = QW'(52'h1_8000_0000_0003);
    localparam logic [QW-1:0] THR2_POS = QW'(52'h1_0000_0000_0000);
    localparam logic [QW-1:0] THR2_NEG = QW'(52'h1_0000_0000_0002);

    localparam logic [XW-1:0] DIV3_MUL   = 49'd375299968947542;
    localparam int            DIV3_SHIFT = 50;

    // xx, yy and zz carry the divide by three
    localparam logic [NCOMP-1:0] DIAG_MASK = 6'b101001;

    typedef logic [MW-1:0] t_mag;

    typedef struct packed {
        logic [NCOMP-1:0]   neg;
        t_mag [NCOMP-1:0]   mag;
    } t_num;

    function automatic t_mag f_mag(input logic signed [MW:0] v);
        t_mag m;
        if (v < 0) begin
            m = MW'(-v);
        end else begin
            m = MW'(v);
        end
        return m;
    endfunction

endpackage

// File: sv/evs_delay.sv
module evs_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_d = r_line[D-1];

endmodule

// File: sv/evs_mul.sv
module evs_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [WA-1:0]   i_a,
    input  logic [WB-1:0]   i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int LIMB = 32;
    localparam int NA   = (WA + LIMB - 1) / LIMB;
    localparam int NB   = (WB + LIMB - 1) / LIMB;
    localparam int WR   = NB * LIMB + LIMB;
    localparam int WP   = NA * LIMB + NB * LIMB;

    logic [NA*LIMB-1:0] a_pad;
    logic [NB*LIMB-1:0] b_pad;

    logic [2*LIMB-1:0] n_pp [NA][NB];
    logic [2*LIMB-1:0] r_pp [NA][NB];
    logic [WR-1:0]     n_row [NA];
    logic [WR-1:0]     r_row [NA];
    logic [WP-1:0]     n_sum;
    logic [WP-1:0]     r_sum;

    assign a_pad = (NA*LIMB)'(i_a);
    assign b_pad = (NB*LIMB)'(i_b);

    // partial products, then row sums, then the total
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = (2*LIMB)'(a_pad[LIMB*i +: LIMB]) * (2*LIMB)'(b_pad[LIMB*j +: LIMB]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WR'(r_pp[i][j]) << (LIMB * j));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (WP'(r_row[i]) << (LIMB * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= n_pp;
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[WA+WB-1:0];

endmodule

// File: sv/evs_isqrt.sv
module evs_isqrt #(
    parameter int W   = 68,
    parameter int SPS = 2
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_x,
    output logic [W/2-1:0] o_root
);

    localparam int HW = W / 2;
    localparam int RW = HW + 2;
    localparam int NS = HW / SPS;

    logic [W-1:0]  a_x    [NS];
    logic [RW-1:0] a_rem  [NS];
    logic [HW-1:0] a_root [NS];
    logic [W-1:0]  n_x    [NS];
    logic [RW-1:0] n_rem  [NS];
    logic [HW-1:0] n_root [NS];
    logic [W-1:0]  r_x    [NS];
    logic [RW-1:0] r_rem  [NS];
    logic [HW-1:0] r_root [NS];

    // restoring root, two radicand bits per step
    always_comb begin
        logic [W-1:0]  x;
        logic [RW-1:0] rem;
        logic [RW-1:0] t;
        logic [HW-1:0] root;
        a_x[0]    = i_x;
        a_rem[0]  = '0;
        a_root[0] = '0;
        for (int k = 1; k < NS; k++) begin
            a_x[k]    = r_x[k-1];
            a_rem[k]  = r_rem[k-1];
            a_root[k] = r_root[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            x    = a_x[k];
            rem  = a_rem[k];
            root = a_root[k];
            for (int s = 0; s < SPS; s++) begin
                rem = {rem[RW-3:0], x[W-1 -: 2]};
                x   = x << 2;
                t   = {root, 2'b01};
                if (rem >= t) begin
                    rem  = rem - t;
                    root = {root[HW-2:0], 1'b1};
                end else begin
                    root = {root[HW-2:0], 1'b0};
                end
            end
            n_x[k]    = x;
            n_rem[k]  = rem;
            n_root[k] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root[NS-1];

endmodule

// File: sv/eddy_viscosity_stress_point.sv
// Eddy-viscosity deviatoric stress, one grid point per beat.
// Input stream: one beat carries the nine velocity gradients, the density and
// the y half spacing of a point. Output stream: one beat with the six stress
// components and a saturation flag in tuser.
// Configuration: spacing_x (index 0) and spacing_z (index 1) are written on the
// plain write port; both reset to 1.0. The user must write them only while the
// block is idle; the block does not enforce it. The 17 stage square root (two
// root bits per stage) is the longest part; the 133 by 34 bit products and the
// divide by three each take three stages of 32 by 32 partial products.
// Throughput: one point per cycle while the receiver takes beats.
// Reset clears every valid bit of the pipeline; no beat is in flight after it.
// When the receiver stalls, the whole pipeline holds and the input side stops
// taking beats; nothing is dropped or repeated, and bubbles are kept.
module eddy_viscosity_stress_point (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // du_dx, du_dy, du_dz, dv_dx, dv_dy, dv_dz, dw_dx, dw_dy, dw_dz, density,
    // half_spacing_y
    input  logic [evs_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // stress_xx, stress_xy, stress_xz, stress_yy, stress_yz, stress_zz
    output logic [evs_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // saturated
    output logic [0:0]                       o_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [evs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [evs_pkg::DW-1:0]           i_cfg_data
);

    import evs_pkg::*;

    localparam int SQ_LAT = SQW / 2 / SQ_SPS;
    localparam int LAT    = 5 + SQ_LAT + 3 * MUL_LAT;

    logic            en;
    logic [LAT-1:0]  r_vld;
    logic [DW-1:0]   r_spacing_x;
    logic [DW-1:0]   r_spacing_z;

    assign en         = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing_x <= SPACING_RESET;
            r_spacing_z <= SPACING_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPACING_X: r_spacing_x <= i_cfg_data;
                REG_SPACING_Z: r_spacing_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: magnitudes and numerators
    logic signed [MW:0] e_g [NUM_GRAD];
    logic signed [MW:0] s_xy, s_xz, s_yz, d_xx, d_yy, d_zz;
    t_mag               n_a_sq [NCOMP];
    t_num               n_a_num;
    t_mag               r_a_sq [NCOMP];
    t_num               r_a_num;
    logic [DW-1:0]      r_a_rho;
    logic [DY2W-1:0]    r_a_dy2;

    always_comb begin
        for (int k = 0; k < NUM_GRAD; k++) begin
            e_g[k] = (MW+1)'(signed'(i_s_tdata[DW*k +: DW]));
        end
        s_xy = e_g[1] + e_g[3];
        s_xz = e_g[2] + e_g[6];
        s_yz = e_g[5] + e_g[7];
        d_xx = (e_g[0] <<< 1) - e_g[4] - e_g[8];
        d_yy = (e_g[4] <<< 1) - e_g[0] - e_g[8];
        d_zz = (e_g[8] <<< 1) - e_g[4] - e_g[0];
        n_a_sq[0] = f_mag(e_g[0]);
        n_a_sq[1] = f_mag(e_g[4]);
        n_a_sq[2] = f_mag(e_g[8]);
        n_a_sq[3] = f_mag(s_xy);
        n_a_sq[4] = f_mag(s_xz);
        n_a_sq[5] = f_mag(s_yz);
        n_a_num.mag[0] = f_mag(d_xx);
        n_a_num.mag[1] = f_mag(s_xy);
        n_a_num.mag[2] = f_mag(s_xz);
        n_a_num.mag[3] = f_mag(d_yy);
        n_a_num.mag[4] = f_mag(s_yz);
        n_a_num.mag[5] = f_mag(d_zz);
        n_a_num.neg = {d_zz[MW], s_yz[MW], d_yy[MW], s_xz[MW], s_xy[MW], d_xx[MW]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sq  <= n_a_sq;
            r_a_num <= n_a_num;
            r_a_rho <= i_s_tdata[DW*9 +: DW];
            r_a_dy2 <= {i_s_tdata[DW*10 +: DW], 1'b0};
        end
    end

    // stage b: squares
    logic [2*MW-1:0]   r_b_sq [NCOMP];
    logic [2*DW-1:0]   r_b_lx;
    logic [2*DY2W-1:0] r_b_ly;
    logic [2*DW-1:0]   r_b_lz;
    logic [DW-1:0]     r_b_rho;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_b_sq[k] <= r_a_sq[k] * r_a_sq[k];
            end
            r_b_lx  <= r_spacing_x * r_spacing_x;
            r_b_ly  <= r_a_dy2 * r_a_dy2;
            r_b_lz  <= r_spacing_z * r_spacing_z;
            r_b_rho <= r_a_rho;
        end
    end

    // stage c: strain argument and spacing sum
    logic [SW-1:0] n_c_s;
    logic [LW-1:0] n_c_len;
    logic [SW-1:0] r_c_s;
    logic [LW-1:0] r_c_len;
    logic [DW-1:0] r_c_rho;

    always_comb begin
        n_c_s = ((SW'(r_b_sq[0]) + SW'(r_b_sq[1]) + SW'(r_b_sq[2])) << 1)
              + SW'(r_b_sq[3]) + SW'(r_b_sq[4]) + SW'(r_b_sq[5]);
        n_c_len = LW'(r_b_lx) + LW'(r_b_ly) + LW'(r_b_lz);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_s   <= n_c_s;
            r_c_len <= n_c_len;
            r_c_rho <= r_b_rho;
        end
    end

    // root, density times spacing, scale
    logic [RTW-1:0] w_root;
    logic [RLW-1:0] w_rl_raw;
    logic [RLW-1:0] w_rl;
    logic [SCW-1:0] w_scale;
    t_num           w_num;
    logic [NCOMP-1:0] w_neg;
    logic [PW-1:0]  w_p [NCOMP];

    evs_isqrt #(.W(SQW), .SPS(SQ_SPS)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (SQW'(r_c_s)),
        .o_root (w_root)
    );

    evs_mul #(.WA(DW), .WB(LW)) u_mul_rl (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_c_rho),
        .i_b   (r_c_len),
        .o_p   (w_rl_raw)
    );

    evs_delay #(.W(RLW), .D(SQ_LAT - MUL_LAT)) u_dly_rl (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_rl_raw),
        .o_d   (w_rl)
    );

    evs_mul #(.WA(RLW), .WB(RTW)) u_mul_scale (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (w_rl),
        .i_b   (w_root),
        .o_p   (w_scale)
    );

    evs_delay #(.W($bits(t_num)), .D(2 + SQ_LAT + MUL_LAT)) u_dly_num (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_a_num),
        .o_d   (w_num)
    );

    evs_delay #(.W(NCOMP), .D(MUL_LAT)) u_dly_neg (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_num.neg),
        .o_d   (w_neg)
    );

    for (genvar k = 0; k < NCOMP; k++) begin : g_comp
        evs_mul #(.WA(SCW), .WB(MW)) u_mul_comp (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (w_scale),
            .i_b   (w_num.mag[k]),
            .o_p   (w_p[k])
        );
    end

    // stage d: saturation check before the divide
    logic [QW-1:0]    q [NCOMP];
    logic [QW-1:0]    thr [NCOMP];
    logic [NCOMP-1:0] n_d_sat;
    logic [XW-1:0]    r_d_x [NCOMP];
    logic [NCOMP-1:0] r_d_sat;
    logic [NCOMP-1:0] r_d_neg;

    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            q[k] = w_p[k][PW-1:Q_SHIFT];
            if (DIAG_MASK[k]) begin
                thr[k] = w_neg[k] ? THR3_NEG : THR3_POS;
            end else begin
                thr[k] = w_neg[k] ? THR2_NEG : THR2_POS;
            end
            n_d_sat[k] = (q[k] >= thr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_d_x[k] <= q[k][XW-1:0];
            end
            r_d_sat <= n_d_sat;
            r_d_neg <= w_neg;
        end
    end

    // divide by three or two
    logic [QDW-1:0]     w_quo [NCOMP];
    logic [2*NCOMP-1:0] w_sn;

    for (genvar k = 0; k < NCOMP; k++) begin : g_div
        if (DIAG_MASK[k]) begin : g_by3
            logic [2*XW-1:0] w_prod;
            evs_mul #(.WA(XW), .WB(XW)) u_mul_div3 (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (r_d_x[k]),
                .i_b   (DIV3_MUL),
                .o_p   (w_prod)
            );
            assign w_quo[k] = w_prod[DIV3_SHIFT +: QDW];
        end else begin : g_by2
            evs_delay #(.W(QDW), .D(MUL_LAT)) u_dly_half (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (r_d_x[k][XW-1:1]),
                .o_d   (w_quo[k])
            );
        end
    end

    evs_delay #(.W(2*NCOMP), .D(MUL_LAT)) u_dly_sn (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_d_sat, r_d_neg}),
        .o_d   (w_sn)
    );

    // stage e: sign, clip, output register
    logic [OUT_TDATA_W-1:0] n_e_data;
    logic [OUT_TDATA_W-1:0] r_e_data;
    logic                   r_e_sat;

    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            if (w_sn[NCOMP + k]) begin
                n_e_data[OW*k +: OW] = w_sn[k] ? NEG_LIMIT : POS_LIMIT;
            end else begin
                n_e_data[OW*k +: OW] = w_sn[k] ? (-w_quo[k]) : w_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_data <= n_e_data;
            r_e_sat  <= |w_sn[2*NCOMP-1:NCOMP];
        end
    end

    assign o_m_tdata    = r_e_data;
    assign o_m_tuser[0] = r_e_sat;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && en |=> r_vld[1])
        else $error("valid bit lost between stages");

    a_sat_hits_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tdata[47:0] == POS_LIMIT || o_m_tdata[47:0] == NEG_LIMIT ||
             o_m_tdata[95:48] == POS_LIMIT || o_m_tdata[95:48] == NEG_LIMIT ||
             o_m_tdata[143:96] == POS_LIMIT || o_m_tdata[143:96] == NEG_LIMIT ||
             o_m_tdata[191:144] == POS_LIMIT || o_m_tdata[191:144] == NEG_LIMIT ||
             o_m_tdata[239:192] == POS_LIMIT || o_m_tdata[239:192] == NEG_LIMIT ||
             o_m_tdata[287:240] == POS_LIMIT || o_m_tdata[287:240] == NEG_LIMIT))
        else $error("saturation flag without a clipped component");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
